@@ rtl/core/tdl_pkg.sv @@
// Shared types, constants and character tables for the table-driven lexer.
`default_nettype none

package tdl_pkg;

   // Field widths
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned CODE_W = 6;
   localparam int unsigned ERR_W  = 2;
   localparam int unsigned TEXT_W = 64;
   localparam int unsigned LEN_W  = 4;
   localparam int unsigned LINE_W = 16;

   // Input kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Token codes
   localparam logic [CODE_W-1:0] TK_IDENT  = 6'd0;
   localparam logic [CODE_W-1:0] TK_NUMBER = 6'd13;
   localparam logic [CODE_W-1:0] TK_OPBASE = 6'd14;
   localparam logic [CODE_W-1:0] TK_END    = 6'd32;
   localparam logic [CODE_W-1:0] TK_ERROR  = 6'd33;

   // Error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE,
      ERR_ILLEGAL,
      ERR_CAPITAL,
      ERR_TOO_LONG
   } err_type;

   // Scanner states; an operator state also keeps the operator index.
   typedef enum logic [1:0] {
      S_START,
      S_IDENT,
      S_NUMBER,
      S_OPER
   } scan_state_type;

   // Character classes
   typedef enum logic [2:0] {
      CL_SPACE,
      CL_UPPER,
      CL_LOWER,
      CL_DIGIT,
      CL_OPER,
      CL_ILLEGAL,
      CL_END
   } class_kind_type;

   typedef struct packed {
      class_kind_type kind;
      logic [4:0]     op_index;
   } char_class_type;

   // One result transaction as held in the output queue.
   typedef struct packed {
      logic [CODE_W-1:0] token_code;
      logic [ERR_W-1:0]  error_code;
      logic [TEXT_W-1:0] token_text;
      logic [LEN_W-1:0]  text_length;
      logic [LINE_W-1:0] line_number;
      logic              last;
   } rsp_item_type;

   // Special characters
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

   // Operator characters in token-code order: = > < : + - * / % . ( ) , { } ; [ ]
   localparam int unsigned OP_COUNT = 18;
   localparam logic [CHAR_W-1:0] OP_CHARS [OP_COUNT] = '{
      8'h3D, 8'h3E, 8'h3C, 8'h3A, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25,
      8'h2E, 8'h28, 8'h29, 8'h2C, 8'h7B, 8'h7D, 8'h3B, 8'h5B, 8'h5D
   };

   // Keywords, first character in the low byte, unused bytes zero:
   // start stop iter void var return read print program iff then let
   localparam int unsigned KW_COUNT = 12;
   localparam logic [TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_0074_7261_7473,
      64'h0000_0000_706F_7473,
      64'h0000_0000_7265_7469,
      64'h0000_0000_6469_6F76,
      64'h0000_0000_0072_6176,
      64'h0000_6E72_7574_6572,
      64'h0000_0000_6461_6572,
      64'h0000_0074_6E69_7270,
      64'h006D_6172_676F_7270,
      64'h0000_0000_0066_6669,
      64'h0000_0000_6E65_6874,
      64'h0000_0000_0074_656C
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd4, 4'd4, 4'd4, 4'd3, 4'd6, 4'd4, 4'd5, 4'd7, 4'd3, 4'd4, 4'd3
   };

   // Sorts one character into its class; operators also give their index.
   function automatic char_class_type classify(input logic [CHAR_W-1:0] c);
      char_class_type cls;
      cls.kind     = CL_ILLEGAL;
      cls.op_index = '0;
      if (c == CH_SPACE) begin
         cls.kind = CL_SPACE;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         cls.kind = CL_UPPER;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         cls.kind = CL_LOWER;
      end else if (c >= CH_0 && c <= CH_9) begin
         cls.kind = CL_DIGIT;
      end else begin
         for (int k = 0; k < OP_COUNT; k++) begin
            if (OP_CHARS[k] == c) begin
               cls.kind     = CL_OPER;
               cls.op_index = 5'(k);
            end
         end
      end
      return cls;
   endfunction

   // Parallel keyword compare; an identifier that matches no keyword keeps code 0.
   function automatic logic [CODE_W-1:0] keyword_code(input logic [TEXT_W-1:0] text,
                                                      input logic [LEN_W-1:0]  len);
      logic [CODE_W-1:0] code;
      code = TK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (KW_TEXT[k] == text && KW_LEN[k] == len) begin
            code = CODE_W'(k + 1);
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tdl_if.sv @@
// Valid/ready channel interfaces for the lexer's character input and token output.
`default_nettype none

interface tdl_req_if import tdl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [CHAR_W-1:0] char_byte;

   modport source (output valid, output kind, output char_byte, input ready);
   modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface tdl_rsp_if import tdl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] token_code;
   logic [ERR_W-1:0]  error_code;
   logic [TEXT_W-1:0] token_text;
   logic [LEN_W-1:0]  text_length;
   logic [LINE_W-1:0] line_number;
   logic              last;

   modport source (output valid, output token_code, output error_code, output token_text,
                   output text_length, output line_number, output last, input ready);
   modport sink   (input valid, input token_code, input error_code, input token_text,
                   input text_length, input line_number, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/table_driven_lexer.sv @@
// A character accepted is held in the input register, then scanned, and its tokens
// are written into the output queue, from which they are valid on the output.
// Throughput: one character per cycle while the output queue has room for ready to stay
// high; an item may yield two tokens, and the 8-entry output queue is drained at one
// token per cycle while the sink is ready.
// Reset: scanner at start with empty text, line count and its register at 1,
// output queue empty.
`default_nettype none

module table_driven_lexer import tdl_pkg::*; #(
   parameter int unsigned MAX_TEXT_CHARS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tdl_req_if.sink                req_bus,
   tdl_rsp_if.source              rsp_bus,
   input  wire logic              csr_wr_en,
   input  wire logic [LINE_W-1:0] csr_wr_data
);

   localparam logic [LEN_W-1:0] MaxChars   = LEN_W'(MAX_TEXT_CHARS);
   localparam int unsigned      FifoDepth  = 8;
   localparam int unsigned      PtrW       = $clog2(FifoDepth);
   localparam int unsigned      CntW       = $clog2(FifoDepth + 1);
   localparam logic [CntW-1:0]  ReadyLimit = CntW'(FifoDepth - 4);

   // Saturating line increment
   function automatic logic [LINE_W-1:0] sat_inc(input logic [LINE_W-1:0] v);
      return (v == '1) ? v : v + LINE_W'(1);
   endfunction

   // Input register
   logic              s1_valid_ff;
   logic              s1_kind_ff;
   logic [CHAR_W-1:0] s1_char_ff;

   // Scanner state
   scan_state_type    scan_ff, scan_in;
   logic [4:0]        op_ff, op_in;
   logic [TEXT_W-1:0] text_ff, text_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LINE_W-1:0] first_line_ff;
   logic              nl_ff, nl_in;
   logic              comment_ff, comment_in;

   // Output queue
   rsp_item_type      queue_ff [FifoDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next_ptr;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   // Scan datapath
   logic              req_accept;
   logic              rsp_accept;
   logic              feed_char;
   logic [CHAR_W-1:0] eff_char;
   char_class_type    cls;
   logic              goes_on;
   logic [CODE_W-1:0] cur_code;
   logic [LINE_W-1:0] line_eff;
   logic              run_start;
   logic              first_emit, second_emit;
   rsp_item_type      first_item, second_item;
   rsp_item_type      res0, res1;
   logic [1:0]        push_cnt;

   // Handshakes: room for two more items' worth of results is kept free.
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (cnt_ff <= ReadyLimit);
   assign rsp_accept    = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff <= req_bus.kind;
         s1_char_ff <= req_bus.char_byte;
      end
   end

   // Classification; a newline is scanned as a space.
   assign eff_char  = (s1_char_ff == CH_LF) ? CH_SPACE : s1_char_ff;
   assign feed_char = (s1_kind_ff == KIND_CHAR) && !comment_ff
                      && (s1_char_ff != CH_AMP) && (s1_char_ff != CH_CR);

   always_comb begin
      if (s1_kind_ff == KIND_END) begin
         cls.kind     = CL_END;
         cls.op_index = '0;
      end else begin
         cls = classify(eff_char);
      end
   end

   assign goes_on = ((scan_ff == S_IDENT)
                     && (cls.kind == CL_UPPER || cls.kind == CL_LOWER || cls.kind == CL_DIGIT))
                    || ((scan_ff == S_NUMBER) && (cls.kind == CL_DIGIT));

   // Code of the token in progress
   always_comb begin
      unique case (scan_ff)
         S_IDENT:  cur_code = keyword_code(text_ff, count_ff);
         S_NUMBER: cur_code = TK_NUMBER;
         S_OPER:   cur_code = TK_OPBASE + CODE_W'(op_ff);
         default:  cur_code = TK_IDENT;
      endcase
   end

   assign line_eff = nl_ff ? sat_inc(line_ff) : line_ff;

   // Next state and results of the item in the input register.
   always_comb begin
      scan_in     = scan_ff;
      op_in       = op_ff;
      text_in     = text_ff;
      count_in    = count_ff;
      line_in     = line_ff;
      nl_in       = nl_ff;
      comment_in  = comment_ff;
      run_start   = 1'b0;
      first_emit  = 1'b0;
      second_emit = 1'b0;
      first_item  = '0;
      second_item = '0;

      if (s1_valid_ff) begin
         line_in = line_eff;
         nl_in   = 1'b0;

         if (s1_kind_ff == KIND_END || feed_char) begin
            // Token in progress: error, extend, or finish it.
            if (scan_ff == S_START) begin
               run_start = 1'b1;
            end else if (cls.kind == CL_ILLEGAL) begin
               first_emit  = 1'b1;
               first_item  = '{TK_ERROR, ERR_ILLEGAL, text_ff, count_ff, line_eff, 1'b0};
               scan_in     = S_START;
               op_in       = '0;
               text_in     = '0;
               count_in    = '0;
            end else if (goes_on) begin
               if (count_ff >= MaxChars) begin
                  first_emit = 1'b1;
                  first_item = '{TK_ERROR, ERR_TOO_LONG, text_ff, count_ff, line_eff, 1'b0};
                  scan_in    = S_START;
                  op_in      = '0;
                  text_in    = '0;
                  count_in   = '0;
               end else begin
                  text_in  = text_ff | (TEXT_W'(eff_char) << {count_ff[2:0], 3'b000});
                  count_in = count_ff + LEN_W'(1);
               end
            end else begin
               first_emit = 1'b1;
               first_item = '{cur_code, ERR_NONE, text_ff, count_ff, line_eff, 1'b0};
               scan_in    = S_START;
               op_in      = '0;
               text_in    = '0;
               count_in   = '0;
               run_start  = 1'b1;
            end

            // The character as seen from the start state.
            if (run_start) begin
               case (cls.kind)
                  CL_LOWER: begin
                     scan_in  = S_IDENT;
                     text_in  = TEXT_W'(eff_char);
                     count_in = LEN_W'(1);
                  end
                  CL_DIGIT: begin
                     scan_in  = S_NUMBER;
                     text_in  = TEXT_W'(eff_char);
                     count_in = LEN_W'(1);
                  end
                  CL_OPER: begin
                     scan_in  = S_OPER;
                     op_in    = cls.op_index;
                     text_in  = TEXT_W'(eff_char);
                     count_in = LEN_W'(1);
                  end
                  CL_UPPER: begin
                     if (first_emit) begin
                        second_emit = 1'b1;
                        second_item = '{TK_ERROR, ERR_CAPITAL, '0, '0, line_eff, 1'b0};
                     end else begin
                        first_emit = 1'b1;
                        first_item = '{TK_ERROR, ERR_CAPITAL, '0, '0, line_eff, 1'b0};
                     end
                  end
                  CL_ILLEGAL: begin
                     first_emit = 1'b1;
                     first_item = '{TK_ERROR, ERR_ILLEGAL, '0, '0, line_eff, 1'b0};
                  end
                  CL_END: begin
                     if (first_emit) begin
                        second_emit = 1'b1;
                        second_item = '{TK_END, ERR_NONE, '0, '0, line_eff, 1'b0};
                     end else begin
                        first_emit = 1'b1;
                        first_item = '{TK_END, ERR_NONE, '0, '0, line_eff, 1'b0};
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Comments, newlines and the end of a source.
         if (s1_kind_ff == KIND_END) begin
            comment_in = 1'b0;
            scan_in    = S_START;
            op_in      = '0;
            text_in    = '0;
            count_in   = '0;
            line_in    = first_line_ff;
         end else if (comment_ff) begin
            if (s1_char_ff == CH_LF) begin
               line_in = sat_inc(line_eff);
            end else if (s1_char_ff == CH_AMP) begin
               comment_in = 1'b0;
            end
         end else if (s1_char_ff == CH_AMP) begin
            comment_in = 1'b1;
         end else if (s1_char_ff == CH_LF) begin
            nl_in = 1'b1;
         end
      end

      // A register write reloads the line count.
      if (csr_wr_en) begin
         line_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= S_START;
         op_ff         <= '0;
         text_ff       <= '0;
         count_ff      <= '0;
         line_ff       <= LINE_W'(1);
         first_line_ff <= LINE_W'(1);
         nl_ff         <= 1'b0;
         comment_ff    <= 1'b0;
      end else begin
         scan_ff    <= scan_in;
         op_ff      <= op_in;
         text_ff    <= text_in;
         count_ff   <= count_in;
         line_ff    <= line_in;
         nl_ff      <= nl_in;
         comment_ff <= comment_in;
         if (csr_wr_en) begin
            first_line_ff <= csr_wr_data;
         end
      end
   end

   // Mark the final result of the item.
   always_comb begin
      res0      = first_item;
      res0.last = !second_emit;
      res1      = second_item;
      res1.last = 1'b1;
      push_cnt  = {1'b0, first_emit} + {1'b0, second_emit};
   end

   // Output queue: up to two writes and one read per cycle.
   assign wr_next_ptr = wr_ptr_ff + PtrW'(1);
   assign wr_ptr_in   = wr_ptr_ff + PtrW'(push_cnt);
   assign rd_ptr_in   = rd_ptr_ff + PtrW'(rsp_accept);
   assign cnt_in      = cnt_ff + CntW'(push_cnt) - CntW'(rsp_accept);

   always_ff @(posedge clock) begin
      if (first_emit) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (second_emit) begin
         queue_ff[wr_next_ptr] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Output transaction
   assign rsp_bus.valid       = (cnt_ff != '0);
   assign rsp_bus.token_code  = queue_ff[rd_ptr_ff].token_code;
   assign rsp_bus.error_code  = queue_ff[rd_ptr_ff].error_code;
   assign rsp_bus.token_text  = queue_ff[rd_ptr_ff].token_text;
   assign rsp_bus.text_length = queue_ff[rd_ptr_ff].text_length;
   assign rsp_bus.line_number = queue_ff[rd_ptr_ff].line_number;
   assign rsp_bus.last        = queue_ff[rd_ptr_ff].last;

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(FifoDepth))
      else $error("Output queue holds more results than its depth.");

   a_text_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxChars)
      else $error("Collected text is longer than the limit.");

   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      scan_ff == S_START |-> (count_ff == '0 && text_ff == '0))
      else $error("Scanner at start with text still collected.");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_kind_ff == KIND_END && !csr_wr_en)
      |=> (scan_ff == S_START && !comment_ff && !nl_ff && line_ff == first_line_ff))
      else $error("End of input did not return the scanner to its initial state.");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      second_emit |-> (first_emit && !res0.last && res1.last))
      else $error("Two results of one item are not marked first and final.");

endmodule

`default_nettype wire
